// ----- design/sorted_keyed_priority_table_unit_assert.svh -----
// Assertion macros for the sorted keyed priority table unit.
`ifndef SORTED_KEYED_PRIORITY_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEYED_PRIORITY_TABLE_UNIT_ASSERT_SVH

// Flag any clock edge at which cond holds.
`define SKPT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Flag an edge where ante holds and cons does not.
`define SKPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/skpt_pkg.sv -----
// Shared types and constants of the sorted keyed priority table unit.
package skpt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 16;
    localparam int PRIO_BITS  = 16;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int POS_BITS   = 4;
    localparam int COUNT_BITS = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_FIND   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DUP     = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]         key;
        logic signed [PRIO_BITS-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic key_eq;
        logic prio_gt;
    } cmp_t;

endpackage

// ----- design/skpt_slot_ram.sv -----
// Slot memory: one write port, one registered read port.
module skpt_slot_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [skpt_pkg::IDX_BITS-1:0] wr_addr,
    input  skpt_pkg::entry_t             wr_data,
    input  logic                         rd_en,
    input  logic [skpt_pkg::IDX_BITS-1:0] rd_addr,
    output skpt_pkg::entry_t             rd_data
);

    skpt_pkg::entry_t mem [skpt_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/skpt_compare.sv -----
// Shared compare unit: key match and priority order of one slot against the request.
module skpt_compare (
    input  skpt_pkg::entry_t              slot,
    input  logic [skpt_pkg::KEY_BITS-1:0] req_key,
    input  logic signed [skpt_pkg::PRIO_BITS-1:0] req_prio,
    output skpt_pkg::cmp_t                result
);

    always_comb
    begin
        result.key_eq  = (slot.key == req_key);
        // a new entry goes after every slot of lower or equal priority
        result.prio_gt = (slot.prio > req_prio);
    end

endmodule

// ----- design/sorted_keyed_priority_table_unit.sv -----
// Top level: sequencer and datapath of the sorted keyed priority table unit.
// Holds up to CAPACITY entries (key, signed priority) in ascending priority order
// in a single-port-read slot memory; one compare unit walks the held slots for every
// operation. A find only scans the held slots; an insert or an erase that changes the table
// scans them, then shifts the slots behind the insert or erase point, one slot per cycle,
// through the single read port of the slot memory. in_ready is high only while no
// operation is in progress; a finished result sits in the output register and the next
// operation may be taken while it waits.
module sorted_keyed_priority_table_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            cmd,
    input  logic [skpt_pkg::KEY_BITS-1:0]         key,
    input  logic signed [skpt_pkg::PRIO_BITS-1:0] priority_req,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic signed [skpt_pkg::PRIO_BITS-1:0] found_priority,
    output logic [skpt_pkg::POS_BITS-1:0]         found_position,
    output logic [skpt_pkg::COUNT_BITS-1:0]       entry_count,
    output logic                                  head_valid,
    output logic [skpt_pkg::KEY_BITS-1:0]         head_key,
    output logic signed [skpt_pkg::PRIO_BITS-1:0] head_priority
);

    localparam int IW = skpt_pkg::IDX_BITS;
    localparam int CW = skpt_pkg::CNT_BITS;

    skpt_pkg::state_t state_reg, state_next;

    logic [1:0]                            cmd_reg, cmd_next;
    logic [skpt_pkg::KEY_BITS-1:0]         key_reg, key_next;
    logic signed [skpt_pkg::PRIO_BITS-1:0] prio_reg, prio_next;
    logic [CW-1:0]                         count_reg, count_next;
    logic [CW-1:0]                         ptr_reg, ptr_next;
    logic [IW-1:0]                         at_reg, at_next;
    logic                                  rd_vld_reg, rd_vld_next;
    logic [IW-1:0]                         rd_idx_reg, rd_idx_next;
    logic                                  match_reg, match_next;
    logic [IW-1:0]                         match_idx_reg, match_idx_next;
    logic signed [skpt_pkg::PRIO_BITS-1:0] match_prio_reg, match_prio_next;
    logic                                  pos_found_reg, pos_found_next;
    logic [IW-1:0]                         pos_reg, pos_next;
    logic [1:0]                            stat_reg, stat_next;
    logic                                  fnd_reg, fnd_next;
    skpt_pkg::entry_t                      head_reg;

    logic                                  out_valid_reg, out_valid_next;
    logic [1:0]                            status_reg;
    logic signed [skpt_pkg::PRIO_BITS-1:0] found_priority_reg;
    logic [skpt_pkg::POS_BITS-1:0]         found_position_reg;
    logic [skpt_pkg::COUNT_BITS-1:0]       entry_count_reg;
    logic                                  head_valid_reg;
    logic [skpt_pkg::KEY_BITS-1:0]         head_key_reg;
    logic signed [skpt_pkg::PRIO_BITS-1:0] head_priority_reg;

    logic             in_xfer;
    logic             scan_end;
    logic             up_end;
    logic             down_end;
    logic             out_load;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    skpt_pkg::entry_t wr_data;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    skpt_pkg::entry_t rd_data;
    skpt_pkg::cmp_t   cmp;

    skpt_slot_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    skpt_compare u_cmp (
        .slot     (rd_data),
        .req_key  (key_reg),
        .req_prio (prio_reg),
        .result   (cmp)
    );

    assign in_ready = (state_reg == skpt_pkg::ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign scan_end = (ptr_reg == count_reg) && !rd_vld_reg;
    assign up_end   = (ptr_reg == CW'(at_reg)) && !rd_vld_reg;
    assign down_end = (ptr_reg == count_reg) && !rd_vld_reg;
    assign out_load = (state_reg == skpt_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skpt_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = skpt_pkg::ST_SCAN;
                end
            end
            skpt_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = skpt_pkg::ST_DONE;
                    if (cmd_reg == skpt_pkg::CMD_INSERT && !match_reg
                        && count_reg != CW'(skpt_pkg::CAPACITY))
                    begin
                        state_next = skpt_pkg::ST_SHIFT_UP;
                    end
                    else if (cmd_reg == skpt_pkg::CMD_ERASE && match_reg)
                    begin
                        state_next = skpt_pkg::ST_SHIFT_DOWN;
                    end
                end
            end
            skpt_pkg::ST_SHIFT_UP:
            begin
                if (up_end)
                begin
                    state_next = skpt_pkg::ST_PLACE;
                end
            end
            skpt_pkg::ST_SHIFT_DOWN:
            begin
                if (down_end)
                begin
                    state_next = skpt_pkg::ST_DONE;
                end
            end
            skpt_pkg::ST_PLACE:
            begin
                state_next = skpt_pkg::ST_DONE;
            end
            skpt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = skpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skpt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        prio_next       = prio_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        at_next         = at_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_prio_next = match_prio_reg;
        pos_found_next  = pos_found_reg;
        pos_next        = pos_reg;
        stat_next       = stat_reg;
        fnd_next        = fnd_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = '0;

        unique case (state_reg)
            skpt_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next       = cmd;
                    key_next       = key;
                    prio_next      = priority_req;
                    ptr_next       = '0;
                    match_next     = 1'b0;
                    pos_found_next = 1'b0;
                    fnd_next       = 1'b0;
                    stat_next      = skpt_pkg::STAT_OK;
                end
            end
            skpt_pkg::ST_SCAN:
            begin
                if (ptr_reg != count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg[IW-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (cmp.key_eq && !match_reg)
                    begin
                        match_next      = 1'b1;
                        match_idx_next  = rd_idx_reg;
                        match_prio_next = rd_data.prio;
                    end
                    if (cmp.prio_gt && !pos_found_reg)
                    begin
                        pos_found_next = 1'b1;
                        pos_next       = rd_idx_reg;
                    end
                end
                if (scan_end)
                begin
                    case (cmd_reg)
                        skpt_pkg::CMD_INSERT:
                        begin
                            if (match_reg)
                            begin
                                stat_next = skpt_pkg::STAT_DUP;
                            end
                            else if (count_reg == CW'(skpt_pkg::CAPACITY))
                            begin
                                stat_next = skpt_pkg::STAT_FULL;
                            end
                            else
                            begin
                                at_next  = pos_found_reg ? pos_reg : count_reg[IW-1:0];
                                ptr_next = count_reg;
                            end
                        end
                        skpt_pkg::CMD_ERASE:
                        begin
                            if (!match_reg)
                            begin
                                stat_next = skpt_pkg::STAT_MISSING;
                            end
                            else
                            begin
                                at_next  = match_idx_reg;
                                ptr_next = CW'(match_idx_reg) + CW'(1);
                            end
                        end
                        skpt_pkg::CMD_FIND:
                        begin
                            if (!match_reg)
                            begin
                                stat_next = skpt_pkg::STAT_MISSING;
                            end
                            else
                            begin
                                fnd_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            stat_next = skpt_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            skpt_pkg::ST_SHIFT_UP:
            begin
                // read slot ptr-1, write it one place later on the next cycle
                if (ptr_reg != CW'(at_reg))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = IW'(ptr_reg - CW'(1));
                    rd_vld_next = 1'b1;
                    rd_idx_next = IW'(ptr_reg - CW'(1));
                    ptr_next    = ptr_reg - CW'(1);
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg + IW'(1);
                end
            end
            skpt_pkg::ST_SHIFT_DOWN:
            begin
                // close the gap: read slot ptr, write it one place earlier
                if (ptr_reg != count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg[IW-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - IW'(1);
                end
                if (down_end)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            skpt_pkg::ST_PLACE:
            begin
                wr_en        = 1'b1;
                wr_addr      = at_reg;
                wr_data.key  = key_reg;
                wr_data.prio = prio_reg;
                count_next   = count_reg + CW'(1);
            end
            skpt_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skpt_pkg::ST_IDLE;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        prio_reg       <= prio_next;
        ptr_reg        <= ptr_next;
        at_reg         <= at_next;
        rd_idx_reg     <= rd_idx_next;
        match_reg      <= match_next;
        match_idx_reg  <= match_idx_next;
        match_prio_reg <= match_prio_next;
        pos_found_reg  <= pos_found_next;
        pos_reg        <= pos_next;
        stat_reg       <= stat_next;
        fnd_reg        <= fnd_next;
        // mirror slot 0 so the head needs no second read port
        if (wr_en && wr_addr == '0)
        begin
            head_reg <= wr_data;
        end
        if (out_load)
        begin
            status_reg         <= stat_reg;
            found_priority_reg <= fnd_reg ? match_prio_reg : '0;
            found_position_reg <= fnd_reg ? skpt_pkg::POS_BITS'(match_idx_reg) : '0;
            entry_count_reg    <= skpt_pkg::COUNT_BITS'(count_reg);
            head_valid_reg     <= (count_reg != '0);
            head_key_reg       <= (count_reg != '0) ? head_reg.key : '0;
            head_priority_reg  <= (count_reg != '0) ? head_reg.prio : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_priority = found_priority_reg;
    assign found_position = found_position_reg;
    assign entry_count    = entry_count_reg;
    assign head_valid     = head_valid_reg;
    assign head_key       = head_key_reg;
    assign head_priority  = head_priority_reg;

`include "sorted_keyed_priority_table_unit_assert.svh"

    `SKPT_ASSERT_NEVER(a_count_bound, count_reg > CW'(skpt_pkg::CAPACITY), "count over capacity")
    `SKPT_ASSERT_IMPLY(a_wr_in_range, wr_en, CW'(wr_addr) <= count_reg, "slot write past entries")
    `SKPT_ASSERT_IMPLY(a_head_flag, out_valid, head_valid == (entry_count != '0), "head flag off")
    `SKPT_ASSERT_IMPLY(a_place_grows, state_reg == skpt_pkg::ST_PLACE, !count_reg[CW-1], "full place")

endmodule
